/* rtl/afs_pkg.sv */
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and codes for the animation frame sequencer: commands, run
// states, play modes, control bits, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package afs_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PLAY  = 2'd1;
    localparam logic [1:0] CMD_PAUSE = 2'd2;

    // run state codes
    localparam logic [1:0] RUN_STOP  = 2'd0;
    localparam logic [1:0] RUN_PLAY  = 2'd1;
    localparam logic [1:0] RUN_PAUSE = 2'd2;

    // play modes, control bits 1:0
    localparam logic [1:0] MODE_ONESHOT  = 2'd0;
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    // control bit positions
    localparam int CTL_STOP     = 2;
    localparam int CTL_ROLLBACK = 3;
    localparam int CTL_SDIR     = 4;
    localparam int CTL_EDIR     = 5;
    localparam int CTL_W        = 6;

    // register indexes
    localparam int          CFG_ADDR_W     = 3;
    localparam int          CFG_DATA_W     = 16;
    localparam logic [2:0]  REG_PERIOD     = 3'd0;
    localparam logic [2:0]  REG_START_FRM  = 3'd1;
    localparam logic [2:0]  REG_END_FRM    = 3'd2;
    localparam logic [2:0]  REG_LAST_FRM   = 3'd3;
    localparam logic [2:0]  REG_START_CYC  = 3'd4;
    localparam logic [2:0]  REG_END_CYC    = 3'd5;
    localparam logic [2:0]  REG_CONTROL    = 3'd6;

    // frame steps taken per tick at most
    localparam int          CNT_W     = 3;
    localparam logic [2:0]  MAX_STEPS = 3'd4;

    // widths of fixed fields
    localparam int PERIOD_W = 16;
    localparam int CYCLE_W  = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        STEP_CONT,
        STEP_STOP,
        STEP_HOLD
    } t_step_res;

endpackage

/* rtl/animation_frame_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// animation_frame_sequencer_unit
// Time-driven frame sequencer: ticks advance frame, direction and cycle
// count in one-shot, loop or ping-pong mode; play and pause set run state.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tuser: cmd; tdata: now_time
//  m_axis    out        tvalid / tready        tdata: frame, dir, cycle, status
//  cfg       in         i_cfg_we (no wait)     i_cfg_addr, i_cfg_wdata
//
//  any beat other than a tick while playing goes from accept through the
//  done state into the output register; the next input beat is taken in idle.
//  a tick while playing first passes the step state, which takes one frame
//  step per cycle through the shared compare-and-subtract of the time
//  remainder against the frame period and leaves once no further step is
//  found or a stop or a one-shot hold ends the tick.
//  the input is ready again once the result sits in the output register,
//  even while that beat still waits; a stalled output holds the sequencer
//  in its final state. reset clears all but r_rem, r_now, r_zero, r_out_data.
//
module animation_frame_sequencer_unit
    import afs_pkg::*;
#(
    parameter int FRAME_BITS = 8,
    parameter int TIME_BITS  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]     i_cfg_wdata,
    // input beats
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // now_time
    input  logic [((TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  logic [1:0]                s_axis_tuser,
    // output beats
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // frame_index, direction, cycle_count, run_status, stopped_now
    output logic [((FRAME_BITS+20+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_W = ((FRAME_BITS + 20 + 7) / 8) * 8;
    localparam int O_DIR = FRAME_BITS;
    localparam int O_CYC = FRAME_BITS + 1;
    localparam int O_RUN = FRAME_BITS + 1 + CYCLE_W;
    localparam int O_STP = FRAME_BITS + 3 + CYCLE_W;

    // configuration registers
    logic [PERIOD_W-1:0]        r_period;
    logic [FRAME_BITS-1:0]      r_start_frm;
    logic [FRAME_BITS-1:0]      r_end_frm;
    logic [FRAME_BITS-1:0]      r_last_frm;
    logic signed [CYCLE_W-1:0]  r_start_cyc;
    logic signed [CYCLE_W-1:0]  r_end_cyc;
    logic [CTL_W-1:0]           r_control;

    // sequencer state
    logic [TIME_BITS-1:0]       r_last_time;
    logic                       r_time_seen;
    logic [FRAME_BITS-1:0]      r_frame;
    logic                       r_dir;
    logic signed [CYCLE_W-1:0]  r_cycle;
    logic [1:0]                 r_run;
    logic                       r_stopped;

    // tick working registers
    logic [TIME_BITS-1:0]       r_rem;
    logic [TIME_BITS-1:0]       r_now;
    logic                       r_zero;
    logic [CNT_W-1:0]           r_cnt;

    t_state                     r_state;
    t_state                     n_state;

    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_data;

    // one frame step results
    logic [FRAME_BITS-1:0]      n_frame;
    logic                       n_dir;
    logic signed [CYCLE_W-1:0]  n_cycle;
    logic                       n_rb_clear;
    t_step_res                  n_res;

    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_can_step;
    logic                       w_do_step;
    logic                       w_load;
    logic [PERIOD_W-1:0]        w_period;
    logic [TIME_BITS-1:0]       w_period_ext;
    logic [TIME_BITS-1:0]       w_in_time;
    logic [1:0]                 w_in_cmd;
    logic [OUT_W-1:0]           w_out_pack;

    assign w_in_time  = s_axis_tdata[TIME_BITS-1:0];
    assign w_in_cmd   = s_axis_tuser;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // shared compare against the frame period, zero period acts as one
    assign w_period     = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign w_period_ext = TIME_BITS'(w_period);
    assign w_can_step   = !r_zero && (r_cnt < MAX_STEPS) && (r_rem >= w_period_ext);

    // configuration registers, roll-back stop clears its control bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_W'(1);
            r_start_frm <= '0;
            r_end_frm   <= '0;
            r_last_frm  <= '1;
            r_start_cyc <= '0;
            r_end_cyc   <= '0;
            r_control   <= CTL_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PERIOD:    r_period    <= i_cfg_wdata;
                REG_START_FRM: r_start_frm <= i_cfg_wdata[FRAME_BITS-1:0];
                REG_END_FRM:   r_end_frm   <= i_cfg_wdata[FRAME_BITS-1:0];
                REG_LAST_FRM:  r_last_frm  <= i_cfg_wdata[FRAME_BITS-1:0];
                REG_START_CYC: r_start_cyc <= i_cfg_wdata;
                REG_END_CYC:   r_end_cyc   <= i_cfg_wdata;
                REG_CONTROL:   r_control   <= i_cfg_wdata[CTL_W-1:0];
                default: ;
            endcase
        end else if (w_do_step && n_rb_clear) begin
            r_control[CTL_ROLLBACK] <= 1'b0;
        end
    end

    // one frame step: stop check, then movement
    always_comb begin
        logic [1:0]                mode;
        logic                      sdir;
        logic                      edir;
        logic signed [CYCLE_W-1:0] cyc;
        mode       = r_control[1:0];
        sdir       = r_control[CTL_SDIR];
        edir       = r_control[CTL_EDIR];
        cyc        = r_cycle;
        n_res      = STEP_CONT;
        n_rb_clear = 1'b0;
        n_frame    = r_frame;
        n_dir      = r_dir;
        if (r_control[CTL_STOP]) begin
            if (r_control[CTL_ROLLBACK]) begin
                if (r_frame == r_start_frm && r_dir == sdir) begin
                    cyc = cyc - CYCLE_W'(1);
                    if (cyc == r_start_cyc) begin
                        n_res      = STEP_STOP;
                        n_rb_clear = 1'b1;
                    end
                end
            end else if (r_frame == r_end_frm && r_dir == edir) begin
                cyc = cyc + CYCLE_W'(1);
                if (cyc == r_end_cyc) begin
                    n_res = STEP_STOP;
                end
            end
        end
        if (n_res != STEP_STOP) begin
            priority if (r_frame == r_end_frm) begin
                if (!r_dir) begin
                    priority if (mode == MODE_LOOP) begin
                        n_frame = r_start_frm;
                        cyc     = cyc + CYCLE_W'(1);
                    end else if (mode == MODE_PINGPONG) begin
                        n_dir   = 1'b1;
                        n_frame = r_frame - FRAME_BITS'(1);
                    end else begin
                        n_res = STEP_HOLD;
                    end
                end else begin
                    n_frame = r_frame - FRAME_BITS'(1);
                end
            end else if (r_frame == r_start_frm) begin
                if (r_dir) begin
                    priority if (mode == MODE_LOOP) begin
                        n_frame = r_end_frm;
                        cyc     = cyc - CYCLE_W'(1);
                    end else if (mode == MODE_PINGPONG) begin
                        n_dir   = 1'b0;
                        n_frame = r_frame + FRAME_BITS'(1);
                    end else begin
                        n_res = STEP_HOLD;
                    end
                end else begin
                    n_frame = r_frame + FRAME_BITS'(1);
                end
            end else if (r_frame == r_last_frm && !r_dir) begin
                n_frame = '0;
            end else if (r_frame == '0 && r_dir) begin
                n_frame = r_last_frm;
            end else if (r_dir) begin
                n_frame = r_frame - FRAME_BITS'(1);
            end else begin
                n_frame = r_frame + FRAME_BITS'(1);
            end
        end
        n_cycle = cyc;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_in_cmd == CMD_TICK && r_time_seen && r_run == RUN_PLAY) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_STEP: begin
                if (!w_can_step || n_res != STEP_CONT) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_do_step     = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_STEP: w_do_step     = w_can_step;
            S_DONE: w_load        = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // position, run state and tick bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_time_seen <= 1'b0;
            r_frame     <= '0;
            r_dir       <= 1'b0;
            r_cycle     <= '0;
            r_run       <= RUN_STOP;
            r_stopped   <= 1'b0;
            r_cnt       <= '0;
        end else if (w_accept) begin
            r_stopped <= 1'b0;
            r_cnt     <= '0;
            unique case (w_in_cmd)
                CMD_TICK: begin
                    if (!r_time_seen) begin
                        r_time_seen <= 1'b1;
                        r_last_time <= w_in_time;
                    end
                end
                CMD_PLAY: begin
                    if (r_run == RUN_STOP) begin
                        r_frame <= r_start_frm;
                        r_dir   <= r_control[CTL_SDIR];
                        r_cycle <= r_start_cyc;
                    end
                    r_run <= RUN_PLAY;
                end
                CMD_PAUSE: begin
                    if (r_run == RUN_PLAY) begin
                        r_run <= RUN_PAUSE;
                    end
                end
                default: ;
            endcase
        end else if (w_do_step) begin
            r_cnt   <= r_cnt + CNT_W'(1);
            r_cycle <= n_cycle;
            if (r_cnt == '0) begin
                r_last_time <= r_now;
            end
            if (n_res == STEP_STOP) begin
                r_run     <= RUN_STOP;
                r_stopped <= 1'b1;
            end else begin
                r_frame <= n_frame;
                r_dir   <= n_dir;
            end
        end
    end

    // time remainder: now - last - 1, reduced by one period per step
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rem  <= w_in_time + ~r_last_time;
            r_zero <= (w_in_time == r_last_time);
            r_now  <= w_in_time;
        end else if (w_do_step) begin
            r_rem <= r_rem - w_period_ext;
        end
    end

    // result packing
    always_comb begin
        w_out_pack                            = '0;
        w_out_pack[FRAME_BITS-1:0]            = r_frame;
        w_out_pack[O_DIR]                     = r_dir;
        w_out_pack[O_CYC +: CYCLE_W]          = r_cycle;
        w_out_pack[O_RUN +: 2]                = r_run;
        w_out_pack[O_STP]                     = r_stopped;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_out_pack;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a stop always leaves the block stopped
    a_stop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[O_STP] |-> r_out_data[O_RUN +: 2] == RUN_STOP)
        else $error("stop reported while not stopped");

    // frame steps per tick stay within the limit
    a_step_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_STEPS)
        else $error("step count above limit");

    // steps are taken only while playing
    a_step_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_step |-> r_run == RUN_PLAY)
        else $error("frame step while not playing");

    // an accepted beat leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accept did not start the sequencer");

    // a waiting result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_data))
        else $error("pending result overwritten");

endmodule

/* tb/sv/tb_animation_frame_sequencer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_animation_frame_sequencer_unit
// Self-checking bench for the frame sequencer. A directed table covers the
// reset state, the first tick, ignored commands, zero and full periods,
// time wrap, step saturation, frame wrap, stops and one-shot hold. Random
// phases with fresh register settings follow. Every output beat is checked
// against an in-bench model of the sequencer, under random idling on both
// streams.
// ----------------------------------------------------------------------------
module tb_animation_frame_sequencer_unit;
    import afs_pkg::*;

    localparam logic [1:0] CMD_IGNORED  = 2'd3;
    localparam int CLK_HALF      = 4;
    localparam int RAND_PHASES   = 20;
    localparam int PHASE_BEATS   = 72;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    // output beat fields, packed as on m_axis_tdata[27:0]
    typedef struct packed {
        logic        stopped;
        logic [1:0]  status;
        logic [15:0] cycle;
        logic        dir;
        logic [7:0]  frame;
    } t_frame_result;

    typedef enum logic { ROW_BEAT, ROW_REG } t_row_kind;

    // one row of the directed table: an input beat or a register write
    typedef struct {
        t_row_kind     kind;
        logic [2:0]    sel;
        logic [31:0]   value;
        bit            known;
        t_frame_result result;
    } t_stim_row;

    localparam t_frame_result AT_RESET = {1'b0, RUN_STOP, 16'd0, 1'b0, 8'd0};
    localparam t_frame_result AT_START = {1'b0, RUN_PLAY, 16'd0, 1'b0, 8'd0};
    localparam t_frame_result AT_WRAP_START = {1'b0, RUN_PLAY, 16'h7FFF, 1'b0, 8'd250};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    // now_time
    logic [31:0]           s_axis_tdata  = '0;
    // cmd
    logic [1:0]            s_axis_tuser  = CMD_TICK;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // frame_index, direction, cycle_count, run_status, stopped_now
    wire  [31:0]           m_axis_tdata;

    animation_frame_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // sequencer model: registers
    logic [15:0] cfg_period    = 16'd1;
    logic [7:0]  cfg_start_frm = 8'd0;
    logic [7:0]  cfg_end_frm   = 8'd0;
    logic [7:0]  cfg_last_frm  = 8'd255;
    logic [15:0] cfg_start_cyc = 16'd0;
    logic [15:0] cfg_end_cyc   = 16'd0;
    logic [5:0]  cfg_ctl       = 6'd1;

    // sequencer model: position and run state
    logic [31:0] seq_last_time = '0;
    logic        seq_time_seen = 1'b0;
    logic [7:0]  seq_frame     = '0;
    logic        seq_dir       = 1'b0;
    logic [15:0] seq_cycle     = '0;
    logic [1:0]  seq_run       = RUN_STOP;

    t_frame_result expected_frames[$];
    t_stim_row     stim_rows[$];
    int            fault_count = 0;
    int            beats_seen  = 0;
    bit            steady_flow = 1'b0;
    int            rdy_hold    = 0;
    logic [31:0]   clock_now   = '0;

    // one frame step of the position
    function automatic t_step_res frame_step();
        logic [1:0] mode;
        logic       sdir;
        logic       edir;
        mode = cfg_ctl[1:0];
        sdir = cfg_ctl[CTL_SDIR];
        edir = cfg_ctl[CTL_EDIR];
        // stop-at-end or roll-back stop
        if (cfg_ctl[CTL_STOP]) begin
            if (cfg_ctl[CTL_ROLLBACK]) begin
                if (seq_frame == cfg_start_frm && seq_dir == sdir) begin
                    seq_cycle = seq_cycle - 16'd1;
                    if (seq_cycle == cfg_start_cyc) begin
                        seq_run = RUN_STOP;
                        cfg_ctl[CTL_ROLLBACK] = 1'b0;
                        return STEP_STOP;
                    end
                end
            end else if (seq_frame == cfg_end_frm && seq_dir == edir) begin
                seq_cycle = seq_cycle + 16'd1;
                if (seq_cycle == cfg_end_cyc) begin
                    seq_run = RUN_STOP;
                    return STEP_STOP;
                end
            end
        end
        // move the frame
        if (seq_frame == cfg_end_frm) begin
            if (!seq_dir) begin
                if (mode == MODE_LOOP) begin
                    seq_frame = cfg_start_frm;
                    seq_cycle = seq_cycle + 16'd1;
                end else if (mode == MODE_PINGPONG) begin
                    seq_dir   = 1'b1;
                    seq_frame = seq_frame - 8'd1;
                end else begin
                    return STEP_HOLD;
                end
            end else begin
                seq_frame = seq_frame - 8'd1;
            end
        end else if (seq_frame == cfg_start_frm) begin
            if (seq_dir) begin
                if (mode == MODE_LOOP) begin
                    seq_frame = cfg_end_frm;
                    seq_cycle = seq_cycle - 16'd1;
                end else if (mode == MODE_PINGPONG) begin
                    seq_dir   = 1'b0;
                    seq_frame = seq_frame + 8'd1;
                end else begin
                    return STEP_HOLD;
                end
            end else begin
                seq_frame = seq_frame + 8'd1;
            end
        end else if (seq_frame == cfg_last_frm && !seq_dir) begin
            seq_frame = 8'd0;
        end else if (seq_frame == 8'd0 && seq_dir) begin
            seq_frame = cfg_last_frm;
        end else if (seq_dir) begin
            seq_frame = seq_frame - 8'd1;
        end else begin
            seq_frame = seq_frame + 8'd1;
        end
        return STEP_CONT;
    endfunction

    // apply one accepted input beat, return the output beat it causes
    function automatic t_frame_result sequence_beat(logic [1:0] cmd, logic [31:0] now);
        logic [31:0]   elapsed;
        logic [31:0]   period;
        logic [31:0]   steps;
        logic [31:0]   k;
        logic          stop_hit;
        logic          done;
        t_step_res     res;
        t_frame_result r;
        stop_hit = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (!seq_time_seen) begin
                    seq_time_seen = 1'b1;
                    seq_last_time = now;
                end else if (seq_run == RUN_PLAY) begin
                    elapsed = now - seq_last_time;
                    period  = (cfg_period == 16'd0) ? 32'd1 : {16'd0, cfg_period};
                    steps   = (elapsed == 32'd0) ? 32'd0 : (elapsed - 32'd1) / period;
                    if (steps != 32'd0) seq_last_time = now;
                    if (steps > 32'(MAX_STEPS)) steps = 32'(MAX_STEPS);
                    k    = 32'd0;
                    done = 1'b0;
                    while (k < steps && !done) begin
                        res = frame_step();
                        if (res == STEP_STOP) stop_hit = 1'b1;
                        if (res != STEP_CONT) done = 1'b1;
                        k = k + 32'd1;
                    end
                end
            end
            CMD_PLAY: begin
                if (seq_run == RUN_STOP) begin
                    seq_frame = cfg_start_frm;
                    seq_dir   = cfg_ctl[CTL_SDIR];
                    seq_cycle = cfg_start_cyc;
                end
                seq_run = RUN_PLAY;
            end
            CMD_PAUSE: begin
                if (seq_run == RUN_PLAY) seq_run = RUN_PAUSE;
            end
            default: ;
        endcase
        r.stopped = stop_hit;
        r.status  = seq_run;
        r.cycle   = seq_cycle;
        r.dir     = seq_dir;
        r.frame   = seq_frame;
        return r;
    endfunction

    // register write into the model copy
    function automatic void mirror_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_PERIOD:    cfg_period    = val;
            REG_START_FRM: cfg_start_frm = val[7:0];
            REG_END_FRM:   cfg_end_frm   = val[7:0];
            REG_LAST_FRM:  cfg_last_frm  = val[7:0];
            REG_START_CYC: cfg_start_cyc = val;
            REG_END_CYC:   cfg_end_cyc   = val;
            REG_CONTROL:   cfg_ctl       = val[5:0];
            default: ;
        endcase
    endfunction

    // gap after a beat: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // table rows
    function automatic t_stim_row beat_row(logic [1:0] cmd, logic [31:0] now);
        t_stim_row row;
        row.kind   = ROW_BEAT;
        row.sel    = {1'b0, cmd};
        row.value  = now;
        row.known  = 1'b0;
        row.result = '0;
        return row;
    endfunction

    function automatic t_stim_row known_row(logic [1:0] cmd, logic [31:0] now,
                                            t_frame_result res);
        t_stim_row row;
        row        = beat_row(cmd, now);
        row.known  = 1'b1;
        row.result = res;
        return row;
    endfunction

    function automatic t_stim_row reg_row(logic [2:0] idx, logic [15:0] val);
        t_stim_row row;
        row        = beat_row(CMD_TICK, {16'd0, val});
        row.kind   = ROW_REG;
        row.sel    = idx;
        return row;
    endfunction

    // directed table
    task automatic load_directed();
        // reset state, first tick, ignored commands, start position
        stim_rows.push_back(known_row(CMD_PAUSE,   32'h0000_0000, AT_RESET));
        stim_rows.push_back(known_row(CMD_TICK,    32'hFFFF_FFF0, AT_RESET));
        stim_rows.push_back(known_row(CMD_IGNORED, 32'h5555_AAAA, AT_RESET));
        stim_rows.push_back(known_row(CMD_PLAY,    32'hAAAA_5555, AT_START));
        // zero period, no elapsed time, saturation, time wrap
        stim_rows.push_back(reg_row(REG_PERIOD, 16'd0));
        stim_rows.push_back(beat_row(CMD_TICK,  32'hFFFF_FFF0));
        stim_rows.push_back(beat_row(CMD_TICK,  32'hFFFF_FFF2));
        stim_rows.push_back(beat_row(CMD_TICK,  32'h0000_0003));
        // ticks while paused are ignored
        stim_rows.push_back(beat_row(CMD_PAUSE, 32'h0000_0000));
        stim_rows.push_back(beat_row(CMD_TICK,  32'h8000_0000));
        stim_rows.push_back(beat_row(CMD_PLAY,  32'h0000_0000));
        stim_rows.push_back(beat_row(CMD_TICK,  32'hFFFF_FFFF));
        // stop at end cycle
        stim_rows.push_back(reg_row(REG_CONTROL, 16'(MODE_LOOP) | (16'd1 << CTL_STOP)));
        stim_rows.push_back(reg_row(REG_END_CYC, 16'd10));
        stim_rows.push_back(beat_row(CMD_TICK,  32'h0000_0001));
        // ping-pong over the frame wrap with the longest period
        stim_rows.push_back(reg_row(REG_START_FRM, 16'd250));
        stim_rows.push_back(reg_row(REG_END_FRM,   16'd3));
        stim_rows.push_back(reg_row(REG_LAST_FRM,  16'd252));
        stim_rows.push_back(reg_row(REG_START_CYC, 16'h7FFF));
        stim_rows.push_back(reg_row(REG_CONTROL,   16'(MODE_PINGPONG)));
        stim_rows.push_back(reg_row(REG_PERIOD,    16'hFFFF));
        stim_rows.push_back(known_row(CMD_PLAY, 32'h0, AT_WRAP_START));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd262142));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd524283));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd786424));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd1048565));
        // one-shot hold, then the unused mode
        stim_rows.push_back(reg_row(REG_PERIOD,  16'd1));
        stim_rows.push_back(reg_row(REG_CONTROL, 16'(MODE_ONESHOT)));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd1048570));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd1048575));
        stim_rows.push_back(reg_row(REG_CONTROL, 16'd3));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd1048580));
        // roll-back with both direction bits set
        stim_rows.push_back(reg_row(REG_CONTROL, 16'(MODE_LOOP) | (16'd1 << CTL_STOP) |
                                    (16'd1 << CTL_ROLLBACK) | (16'd1 << CTL_SDIR) |
                                    (16'd1 << CTL_EDIR)));
        stim_rows.push_back(reg_row(REG_END_CYC, 16'h8000));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd1048585));
        stim_rows.push_back(beat_row(CMD_TICK, 32'd1048590));
    endtask

    // present one input beat and wait for its accept
    task automatic send_beat(input logic [1:0] cmd, input logic [31:0] now,
                             input bit known, input t_frame_result typed);
        t_frame_result want;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= now;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        want = sequence_beat(cmd, now);
        expected_frames.push_back(known ? typed : want);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off input until every expected beat is out, then let it settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, enable left high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        mirror_reg(idx, val);
        @(posedge i_clk);
    endtask

    // fresh settings for one random phase, the first two at the extremes
    task automatic program_phase(input int ph);
        logic [15:0] period;
        logic [15:0] start_cyc;
        logic [15:0] end_cyc;
        logic [15:0] base;
        logic [7:0]  last;
        logic [7:0]  first_frm;
        logic [7:0]  end_frm;
        logic [5:0]  ctl;
        if (ph == 0) begin
            period = 16'hFFFF; last = 8'hFF; first_frm = 8'hFF; end_frm = 8'hFF;
            start_cyc = 16'h7FFF; end_cyc = 16'h7FFF; ctl = 6'h3F;
        end else if (ph == 1) begin
            period = 16'd0; last = 8'd0; first_frm = 8'd0; end_frm = 8'd0;
            start_cyc = 16'h8000; end_cyc = 16'h8000; ctl = 6'h00;
        end else begin
            case ($urandom_range(0, 9))
                0:       period = 16'd0;
                1:       period = 16'hFFFF;
                2, 3:    period = 16'($urandom_range(5, 400));
                default: period = 16'($urandom_range(1, 4));
            endcase
            last = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
            if ($urandom_range(0, 4) == 0) begin
                first_frm = 8'($urandom);
                end_frm   = 8'($urandom);
            end else begin
                // keep the range inside the frame store so the end is reached
                first_frm = 8'($urandom_range(0, last));
                end_frm   = $urandom_range(0, 1) ? first_frm + 8'($urandom_range(0, 5))
                                                 : 8'($urandom_range(0, last));
                if (end_frm > last) end_frm = last;
            end
            // cycle targets near the running count so stops are reached
            base      = seq_cycle;
            start_cyc = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                    : base - 16'($urandom_range(0, 4));
            end_cyc   = ($urandom_range(0, 1) ? base : start_cyc) +
                        16'($urandom_range(1, 4));
            ctl       = 6'($urandom_range(0, 63));
        end
        write_reg(REG_PERIOD,    period);
        write_reg(REG_START_FRM, {8'd0, first_frm});
        write_reg(REG_END_FRM,   {8'd0, end_frm});
        write_reg(REG_LAST_FRM,  {8'd0, last});
        write_reg(REG_START_CYC, start_cyc);
        write_reg(REG_END_CYC,   end_cyc);
        write_reg(REG_CONTROL,   {10'd0, ctl});
    endtask

    // output stall pattern
    always @(posedge i_clk) begin
        int r;
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (steady_flow) begin
            m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_axis_tready <= 1'b1;
                rdy_hold      <= $urandom_range(0, 7);
            end else if (r < 95) begin
                m_axis_tready <= 1'b0;
                rdy_hold      <= $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                rdy_hold      <= $urandom_range(10, 40);
            end
        end
    end

    // output beat check
    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[27:0];
            if (expected_frames.size() == 0) begin
                if (fault_count < MAX_REPORTS)
                    $display("output beat %0d arrived with nothing expected: %h",
                             beats_seen, got);
                fault_count = fault_count + 1;
            end else begin
                want = expected_frames.pop_front();
                if (got.frame !== want.frame || got.dir !== want.dir ||
                    got.cycle !== want.cycle || got.status !== want.status ||
                    got.stopped !== want.stopped) begin
                    if (fault_count < MAX_REPORTS) begin
                        $display("mismatch on output beat %0d (expected/actual):",
                                 beats_seen);
                        $display("  frame %0d/%0d dir %0d/%0d cycle %0d/%0d",
                                 want.frame, got.frame, want.dir, got.dir,
                                 $signed(want.cycle), $signed(got.cycle));
                        $display("  status %0d/%0d stop %0d/%0d",
                                 want.status, got.status, want.stopped, got.stopped);
                    end
                    fault_count = fault_count + 1;
                end
            end
            beats_seen = beats_seen + 1;
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial begin
        t_stim_row  row;
        t_row_kind  prev_kind;
        logic [1:0] cmd;
        logic [31:0] now;
        int         n;
        int         ph;
        int         b;
        int         r;
        int         pe;
        load_directed();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        prev_kind = ROW_BEAT;
        for (n = 0; n < stim_rows.size(); n++) begin
            row = stim_rows[n];
            if (row.kind == ROW_REG) begin
                if (prev_kind == ROW_BEAT) wait_idle();
                write_reg(row.sel, row.value[15:0]);
            end else begin
                if (i_cfg_we) i_cfg_we <= 1'b0;
                send_beat(row.sel[1:0], row.value, row.known, row.result);
            end
            prev_kind = row.kind;
        end
        clock_now = 32'd1048590;

        // random phases: mostly play followed by ticks of a few frame periods
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            program_phase(ph);
            i_cfg_we    <= 1'b0;
            steady_flow = (ph % 5 == 2);
            for (b = 0; b < PHASE_BEATS; b++) begin
                pe = (cfg_period == 16'd0) ? 1 : int'(cfg_period);
                r  = $urandom_range(0, 99);
                if (seq_run != RUN_PLAY && r < 50) cmd = CMD_PLAY;
                else begin
                    r = $urandom_range(0, 99);
                    if (r < 80)      cmd = CMD_TICK;
                    else if (r < 87) cmd = CMD_PLAY;
                    else if (r < 95) cmd = CMD_PAUSE;
                    else             cmd = CMD_IGNORED;
                end
                if (cmd == CMD_TICK) begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        clock_now = $urandom;
                    else if (r >= 13)
                        clock_now = clock_now + $urandom_range(0, pe * 5 + 1);
                    now = clock_now;
                end else begin
                    now = $urandom;
                end
                send_beat(cmd, now, 1'b0, '0);
            end
        end

        steady_flow = 1'b0;
        wait_idle();
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/afs_pkg.sv
rtl/animation_frame_sequencer_unit.sv
tb/sv/tb_animation_frame_sequencer_unit.sv
